FILE: src/ifrt_pkg.sv
// ----------------------------------------------------------------------------
// ifrt_pkg
// Types and constants shared by the IPv4 fragment reassembly tracker.
// ----------------------------------------------------------------------------
package ifrt_pkg;

  localparam int TABLE_ENTRIES_DEF = 8;

  localparam logic [15:0] MIN_FRAME_LEN = 16'd20;
  localparam logic [16:0] RECEIVED_MAX  = 17'h1FFFF;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [1:0] CLASS_ICMP    = 2'd0;
  localparam logic [1:0] CLASS_UDP     = 2'd1;
  localparam logic [1:0] CLASS_TCP     = 2'd2;
  localparam logic [1:0] CLASS_UNKNOWN = 2'd3;

  localparam logic [2:0] STAT_TOO_SHORT  = 3'd0;
  localparam logic [2:0] STAT_BAD_LENGTH = 3'd1;
  localparam logic [2:0] STAT_DELIVER    = 3'd2;
  localparam logic [2:0] STAT_HELD       = 3'd3;
  localparam logic [2:0] STAT_REASSEMBLED = 3'd4;
  localparam logic [2:0] STAT_TABLE_FULL = 3'd5;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [3:0]  header_words;
    logic [15:0] ip_length;
    logic [12:0] frag_offset;
    logic        more_fragments;
    logic [7:0]  proto_number;
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic [15:0] identification;
  } ifrt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  entry_index;
    logic [5:0]  payload_start;
    logic [15:0] write_offset;
    logic [15:0] payload_length;
    logic [16:0] deliver_length;
    logic [1:0]  protocol_class;
  } ifrt_out_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] ident;
    logic [7:0]  proto;
    logic [16:0] extent;
    logic [16:0] received;
    logic        end_seen;
  } ifrt_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DECIDE,
    S_FINISH
  } ifrt_state_t;

endpackage

FILE: src/ipv4_fragment_reassembly_tracker_unit.sv
// ----------------------------------------------------------------------------
// ipv4_fragment_reassembly_tracker_unit
// Classifies parsed IPv4 headers and tracks fragments in a keyed slot table.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; exactly one result
// follows on out_item with a one-cycle out_strobe, and the receiver cannot
// stall it. A frame that is too short or has a bad length gives its result
// from S_CHECK. Every other item scans the slot table through one RAM read
// port, one slot per cycle, then goes to S_DECIDE: a whole datagram or a table
// full drop gives its result from there, a held or reassembled fragment
// passes on to S_FINISH after the table write. busy drops in the cycle
// out_strobe is high, so the next item can be taken at the edge that ends the
// result. Valid bits sit in flip-flops cleared by reset, so no clearing pass
// is needed.
module ipv4_fragment_reassembly_tracker_unit #(
  parameter int TABLE_ENTRIES = ifrt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ifrt_pkg::ifrt_in_t in_item,
  output logic               out_strobe,
  output ifrt_pkg::ifrt_out_t out_item
);
  import ifrt_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int ENT_W = $bits(ifrt_entry_t);

  function automatic logic [1:0] proto_class(input logic [7:0] proto);
    logic [1:0] c;
    case (proto)
      PROTO_ICMP: c = CLASS_ICMP;
      PROTO_UDP:  c = CLASS_UDP;
      PROTO_TCP:  c = CLASS_TCP;
      default:    c = CLASS_UNKNOWN;
    endcase
    return c;
  endfunction

  ifrt_state_t state_r, state_nxt;
  ifrt_in_t    in_r, in_nxt;
  ifrt_out_t   out_r, out_nxt;
  logic        strobe_r, strobe_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0] payload_r, payload_nxt;
  logic [16:0] need_r, need_nxt;
  logic        found_r, found_nxt;
  logic        free_found_r, free_found_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  ifrt_entry_t hit_ent_r, hit_ent_nxt;
  ifrt_entry_t new_ent_r, new_ent_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  ifrt_entry_t      wr_data;
  ifrt_entry_t      rd_ent;
  logic [ENT_W-1:0] rd_bits;

  logic [5:0]       hdr;
  logic [15:0]      offset8;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] cmp_idx;
  logic             key_match;
  logic [17:0]      rec_sum;
  logic [16:0]      rec_sat;
  logic [IDX_W+2:0] slot_wide;
  ifrt_entry_t      base_ent;

  ifrt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES),
    .AW    (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (cnt_r[IDX_W-1:0]),
    .rd_data (rd_bits)
  );

  assign rd_ent = ifrt_entry_t'(rd_bits);

  assign hdr       = {in_r.header_words, 2'b00};
  assign offset8   = {in_r.frag_offset, 3'b000};
  assign cnt_m1    = cnt_r - CNT_W'(1);
  assign cmp_idx   = cnt_m1[IDX_W-1:0];
  assign key_match = (rd_ent.src == in_r.src_address) && (rd_ent.dst == in_r.dst_address) &&
                     (rd_ent.ident == in_r.identification) &&
                     (rd_ent.proto == in_r.proto_number);
  assign slot_wide = {3'b000, slot_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
      valid_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r         <= in_nxt;
    out_r        <= out_nxt;
    cnt_r        <= cnt_nxt;
    payload_r    <= payload_nxt;
    need_r       <= need_nxt;
    found_r      <= found_nxt;
    free_found_r <= free_found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    slot_r       <= slot_nxt;
    hit_ent_r    <= hit_ent_nxt;
    new_ent_r    <= new_ent_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    in_nxt         = in_r;
    out_nxt        = out_r;
    strobe_nxt     = 1'b0;
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    payload_nxt    = payload_r;
    need_nxt       = need_r;
    found_nxt      = found_r;
    free_found_nxt = free_found_r;
    hit_idx_nxt    = hit_idx_r;
    free_idx_nxt   = free_idx_r;
    slot_nxt       = slot_r;
    hit_ent_nxt    = hit_ent_r;
    new_ent_nxt    = new_ent_r;
    wr_en          = 1'b0;
    wr_addr        = slot_r;
    wr_data        = new_ent_r;
    base_ent       = hit_ent_r;
    rec_sum        = '0;
    rec_sat        = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          in_nxt    = in_item;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        out_nxt = '0;
        if (in_r.frame_length < MIN_FRAME_LEN) begin
          out_nxt.status = STAT_TOO_SHORT;
          strobe_nxt     = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          out_nxt.payload_start  = hdr;
          out_nxt.protocol_class = proto_class(in_r.proto_number);
          if ((in_r.ip_length < {10'd0, hdr}) ||
              (in_r.ip_length > in_r.frame_length)) begin
            out_nxt.status = STAT_BAD_LENGTH;
            strobe_nxt     = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            payload_nxt    = in_r.ip_length - {10'd0, hdr};
            cnt_nxt        = '0;
            found_nxt      = 1'b0;
            free_found_nxt = 1'b0;
            state_nxt      = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        need_nxt = {1'b0, offset8} + {1'b0, payload_r};
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r != '0) begin
          if (valid_r[cmp_idx]) begin
            if (key_match && !found_r) begin
              found_nxt   = 1'b1;
              hit_idx_nxt = cmp_idx;
              hit_ent_nxt = rd_ent;
            end
          end else if (!free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = cmp_idx;
          end
        end
        if (cnt_r == CNT_W'(TABLE_ENTRIES)) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        out_nxt.payload_length = payload_r;
        if ((in_r.frag_offset == '0) && !in_r.more_fragments) begin
          if (found_r) begin
            valid_nxt[hit_idx_r] = 1'b0;
          end
          out_nxt.status         = STAT_DELIVER;
          out_nxt.deliver_length = {1'b0, payload_r};
          strobe_nxt             = 1'b1;
          state_nxt              = S_IDLE;
        end else begin
          out_nxt.write_offset = offset8;
          if (!found_r && !free_found_r) begin
            out_nxt.status = STAT_TABLE_FULL;
            strobe_nxt     = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            slot_nxt = found_r ? hit_idx_r : free_idx_r;
            if (!found_r) begin
              base_ent.extent   = '0;
              base_ent.received = '0;
              base_ent.end_seen = 1'b0;
            end
            rec_sum = {1'b0, base_ent.received} + {2'b00, payload_r};
            rec_sat = rec_sum[17] ? RECEIVED_MAX : rec_sum[16:0];
            new_ent_nxt.src      = in_r.src_address;
            new_ent_nxt.dst      = in_r.dst_address;
            new_ent_nxt.ident    = in_r.identification;
            new_ent_nxt.proto    = in_r.proto_number;
            new_ent_nxt.extent   = (need_r > base_ent.extent) ? need_r : base_ent.extent;
            new_ent_nxt.received = rec_sat;
            new_ent_nxt.end_seen = base_ent.end_seen | ~in_r.more_fragments;
            wr_en                = 1'b1;
            wr_addr              = slot_nxt;
            wr_data              = new_ent_nxt;
            valid_nxt[slot_nxt]  = 1'b1;
            state_nxt            = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        out_nxt.entry_index = slot_wide[2:0];
        if (new_ent_r.end_seen && (new_ent_r.extent == new_ent_r.received)) begin
          out_nxt.status         = STAT_REASSEMBLED;
          out_nxt.deliver_length = new_ent_r.extent;
          valid_nxt[slot_r]      = 1'b0;
        end else begin
          out_nxt.status = STAT_HELD;
        end
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_item   = out_r;

endmodule

FILE: src/ifrt_ram.sv
// ----------------------------------------------------------------------------
// ifrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ifrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: verif/ipv4_fragment_reassembly_tracker_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv4_fragment_reassembly_tracker_unit_tb
// Drives parsed IPv4 headers into the tracker and checks every result against
// a local model of the slot table: length checks, whole delivery, held and
// reassembled fragments, table full drops and received count saturation,
// followed by random interleaved datagrams with broken sequences and noise.
// ----------------------------------------------------------------------------
module ipv4_fragment_reassembly_tracker_unit_tb;
  import ifrt_pkg::*;

  localparam int TBL         = TABLE_ENTRIES_DEF;
  localparam int FLOWS       = 12;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] ident;
    logic [7:0]  proto;
  } flow_key_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  ifrt_in_t  in_item;
  logic      out_strobe;
  ifrt_out_t out_item;

  logic        slot_live [TBL];
  ifrt_entry_t slot_tab [TBL];
  flow_key_t   flow_pool [FLOWS];
  ifrt_out_t   verdicts_due [$];
  int          bad_verdicts;
  int          items_sent;
  int          quiet_cycles;
  logic        steady_feed;

  ipv4_fragment_reassembly_tracker_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Expected verdict for one accepted header; updates the local slot table.
  function automatic ifrt_out_t track_header(input ifrt_in_t h);
    ifrt_out_t   r;
    logic [5:0]  hdr;
    logic [15:0] pay;
    logic [15:0] off8;
    logic [16:0] need;
    logic [17:0] rec;
    int          hit;
    int          i;
    r = '0;
    if (h.frame_length < MIN_FRAME_LEN) begin
      r.status = STAT_TOO_SHORT;
      return r;
    end
    hdr = {h.header_words, 2'b00};
    r.payload_start = hdr;
    case (h.proto_number)
      PROTO_ICMP: r.protocol_class = CLASS_ICMP;
      PROTO_UDP:  r.protocol_class = CLASS_UDP;
      PROTO_TCP:  r.protocol_class = CLASS_TCP;
      default:    r.protocol_class = CLASS_UNKNOWN;
    endcase
    if (h.ip_length < {10'd0, hdr} || h.ip_length > h.frame_length) begin
      r.status = STAT_BAD_LENGTH;
      return r;
    end
    pay = h.ip_length - {10'd0, hdr};
    off8 = {h.frag_offset, 3'b000};
    r.payload_length = pay;
    hit = -1;
    for (i = 0; i < TBL; i++) begin
      if (hit < 0 && slot_live[i] && slot_tab[i].src == h.src_address &&
          slot_tab[i].dst == h.dst_address && slot_tab[i].ident == h.identification &&
          slot_tab[i].proto == h.proto_number)
        hit = i;
    end
    if (off8 == '0 && !h.more_fragments) begin
      if (hit >= 0) slot_live[hit] = 1'b0;
      r.status = STAT_DELIVER;
      r.deliver_length = {1'b0, pay};
      return r;
    end
    r.write_offset = off8;
    if (hit < 0) begin
      for (i = 0; i < TBL; i++) begin
        if (hit < 0 && !slot_live[i]) hit = i;
      end
      if (hit < 0) begin
        r.status = STAT_TABLE_FULL;
        return r;
      end
      slot_live[hit] = 1'b1;
      slot_tab[hit] = {h.src_address, h.dst_address, h.identification, h.proto_number,
                       17'd0, 17'd0, 1'b0};
    end
    need = {1'b0, off8} + {1'b0, pay};
    rec = {1'b0, slot_tab[hit].received} + {2'b00, pay};
    if (need > slot_tab[hit].extent) slot_tab[hit].extent = need;
    if (!h.more_fragments) slot_tab[hit].end_seen = 1'b1;
    slot_tab[hit].received = (rec > {1'b0, RECEIVED_MAX}) ? RECEIVED_MAX : rec[16:0];
    r.entry_index = hit[2:0];
    if (slot_tab[hit].end_seen && slot_tab[hit].extent == slot_tab[hit].received) begin
      r.status = STAT_REASSEMBLED;
      r.deliver_length = slot_tab[hit].extent;
      slot_live[hit] = 1'b0;
    end else begin
      r.status = STAT_HELD;
    end
    return r;
  endfunction

  // Well-formed header of a flow; frame holds the whole packet plus some slack.
  function automatic ifrt_in_t fragment_of(input flow_key_t k, input logic [3:0] ihl,
                                           input int unsigned pay, input logic [12:0] off,
                                           input logic mf);
    ifrt_in_t    h;
    int unsigned tot;
    int unsigned frm;
    tot = ihl * 4 + pay;
    frm = tot + $urandom_range(0, 24);
    if (frm > 65535) frm = 65535;
    if (frm < 20) frm = 20 + $urandom_range(0, 8);
    h.frame_length   = frm[15:0];
    h.header_words   = ihl;
    h.ip_length      = tot[15:0];
    h.frag_offset    = off;
    h.more_fragments = mf;
    h.proto_number   = k.proto;
    h.src_address    = k.src;
    h.dst_address    = k.dst;
    h.identification = k.ident;
    return h;
  endfunction

  always @(posedge clk) begin : check_results
    ifrt_out_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (verdicts_due.size() == 0) begin
          bad_verdicts++;
          if (bad_verdicts <= 10)
            $display("result with nothing pending: status %0d slot %0d",
                     out_item.status, out_item.entry_index);
        end else begin
          want = verdicts_due.pop_front();
          if (out_item !== want) begin
            bad_verdicts++;
            if (bad_verdicts <= 10) begin
              $write("mismatch exp/act: status %0d/%0d slot %0d/%0d start %0d/%0d",
                     want.status, out_item.status, want.entry_index, out_item.entry_index,
                     want.payload_start, out_item.payload_start);
              $display(" woff %0d/%0d plen %0d/%0d dlen %0d/%0d class %0d/%0d",
                       want.write_offset, out_item.write_offset,
                       want.payload_length, out_item.payload_length,
                       want.deliver_length, out_item.deliver_length,
                       want.protocol_class, out_item.protocol_class);
            end
          end
        end
      end
      if (start && !busy) verdicts_due.push_back(track_header(in_item));
      if ((start && !busy) || out_strobe)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_item(input ifrt_in_t h);
    int           gap;
    logic [159:0] junk;
    if (!steady_feed && $urandom_range(0, 99) < 17) begin
      gap = $urandom_range(1, 20);
      junk = {$urandom, $urandom, $urandom, $urandom, $urandom};
      start <= 1'b0;
      in_item <= junk[$bits(ifrt_in_t)-1:0];
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= h;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(negedge clk); while (verdicts_due.size() != 0);
    @(posedge clk);
  endtask

  task automatic test_length_checks();
    ifrt_in_t h;
    h = '1;
    h.frame_length = 16'd0;
    send_item(h);
    h = fragment_of(flow_pool[11], 4'd5, 0, '0, 1'b0);
    h.frame_length = 16'd19;
    send_item(h);
    h.header_words = 4'd15;
    h.frame_length = 16'd100;
    h.ip_length = 16'd59;
    send_item(h);
    h.header_words = 4'd5;
    h.ip_length = 16'd101;
    send_item(h);
    h.header_words = 4'd15;
    h.frame_length = 16'd40;
    h.ip_length = 16'd60;
    send_item(h);
  endtask

  task automatic test_whole_datagrams();
    ifrt_in_t h;
    h = fragment_of(flow_pool[0], 4'd5, 0, '0, 1'b0);
    h.frame_length = 16'd20;
    h.proto_number = PROTO_ICMP;
    send_item(h);
    h = fragment_of(flow_pool[1], 4'd0, 30, '0, 1'b0);
    h.proto_number = PROTO_UDP;
    send_item(h);
    h = '1;
    h.frag_offset = '0;
    h.more_fragments = 1'b0;
    send_item(h);
  endtask

  task automatic test_out_of_order_reassembly();
    send_item(fragment_of(flow_pool[0], 4'd5, 8, 13'd2, 1'b0));
    send_item(fragment_of(flow_pool[0], 4'd7, 16, 13'd0, 1'b1));
  endtask

  task automatic test_whole_frees_slot();
    send_item(fragment_of(flow_pool[1], 4'd6, 24, 13'd0, 1'b1));
    send_item(fragment_of(flow_pool[1], 4'd5, 100, 13'd0, 1'b0));
  endtask

  // Received count saturates on one flow while the table fills, then clear.
  task automatic test_table_full_and_saturation();
    int i;
    repeat (3) send_item(fragment_of(flow_pool[2], 4'd0, 65535, 13'd0, 1'b1));
    for (i = 3; i < 10; i++) begin
      if (i == 9)
        send_item(fragment_of(flow_pool[i], 4'd5, 8, 13'h1FFF, 1'b0));
      else
        send_item(fragment_of(flow_pool[i], 4'd5, 8, 13'(i), 1'b1));
    end
    send_item(fragment_of(flow_pool[10], 4'd5, 8, 13'd1, 1'b1));
    for (i = 2; i < 10; i++)
      send_item(fragment_of(flow_pool[i], 4'd5, $urandom_range(0, 100), '0, 1'b0));
  endtask

  // A few interleaved datagrams of pool flows, some broken, plus noise.
  task automatic send_datagram_mix();
    ifrt_in_t    frags [$];
    ifrt_in_t    h;
    flow_key_t   fk;
    int          n_frag;
    int          pay;
    int          j;
    int          k;
    logic [12:0] off;
    logic [3:0]  ihl;
    logic        large_dg;
    repeat ($urandom_range(1, 3)) begin
      fk = flow_pool[$urandom_range(0, FLOWS - 1)];
      large_dg = ($urandom_range(0, 99) < 4);
      n_frag = large_dg ? 2 : $urandom_range(1, 4);
      off = '0;
      for (j = 0; j < n_frag; j++) begin
        if (j == n_frag - 1)
          pay = large_dg ? $urandom_range(0, 65475) : $urandom_range(0, 40);
        else
          pay = 8 * (large_dg ? $urandom_range(4000, 8100) : $urandom_range(1, 6));
        ihl = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 4)) :
                                            4'($urandom_range(5, 15));
        frags.push_back(fragment_of(fk, ihl, pay, off, j != n_frag - 1));
        off = off + 13'(pay / 8);
      end
      if (n_frag > 1 && $urandom_range(0, 99) < 12)
        frags.delete($urandom_range(0, frags.size() - 1));
      else if ($urandom_range(0, 99) < 8)
        frags.push_back(frags[$urandom_range(0, frags.size() - 1)]);
    end
    if ($urandom_range(0, 1) == 1) begin
      for (j = frags.size() - 1; j > 0; j--) begin
        k = $urandom_range(0, j);
        h = frags[j];
        frags[j] = frags[k];
        frags[k] = h;
      end
    end
    if ($urandom_range(0, 99) < 25)
      frags.push_back(fragment_of(flow_pool[$urandom_range(0, FLOWS - 1)], 4'd5,
                                  $urandom_range(0, 200), '0, 1'b0));
    if ($urandom_range(0, 99) < 15) begin
      h.frame_length   = 16'($urandom_range(0, 65535));
      h.header_words   = 4'($urandom_range(0, 15));
      h.ip_length      = 16'($urandom_range(0, 65535));
      h.frag_offset    = 13'($urandom_range(0, 8191));
      h.more_fragments = 1'($urandom_range(0, 1));
      h.proto_number   = 8'($urandom_range(0, 255));
      h.src_address    = $urandom;
      h.dst_address    = $urandom;
      h.identification = 16'($urandom_range(0, 65535));
      frags.push_back(h);
      // a stray fragment that got a slot is released by a whole packet of its flow
      if (h.frame_length >= MIN_FRAME_LEN && h.ip_length >= {10'd0, h.header_words, 2'b00}
          && h.ip_length <= h.frame_length && (h.frag_offset != '0 || h.more_fragments))
        frags.push_back(fragment_of({h.src_address, h.dst_address, h.identification,
                                     h.proto_number}, 4'd5, $urandom_range(0, 40), '0, 1'b0));
    end
    foreach (frags[n]) send_item(frags[n]);
    if (!steady_feed && $urandom_range(0, 99) < 5) hold_until_drained();
  endtask

  task automatic test_random_traffic(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) send_datagram_mix();
  endtask

  task automatic test_steady_stream(input int n);
    int target;
    target = items_sent + n;
    steady_feed = 1'b1;
    while (items_sent < target) send_datagram_mix();
    steady_feed = 1'b0;
  endtask

  initial begin
    int i;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    bad_verdicts = 0;
    items_sent = 0;
    quiet_cycles = 0;
    steady_feed = 1'b0;
    for (i = 0; i < TBL; i++) slot_live[i] = 1'b0;
    for (i = 0; i < FLOWS; i++) begin
      flow_pool[i].src = $urandom;
      flow_pool[i].dst = $urandom;
      flow_pool[i].ident = 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 3))
        0:       flow_pool[i].proto = PROTO_ICMP;
        1:       flow_pool[i].proto = PROTO_UDP;
        2:       flow_pool[i].proto = PROTO_TCP;
        default: flow_pool[i].proto = 8'($urandom_range(0, 255));
      endcase
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_length_checks();
    test_whole_datagrams();
    test_out_of_order_reassembly();
    test_whole_frees_slot();
    hold_until_drained();
    test_table_full_and_saturation();
    test_random_traffic(450);
    test_steady_stream(150);
    hold_until_drained();
    repeat (24) @(posedge clk);
    if (bad_verdicts == 0 && verdicts_due.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
